/* src/process_table_round_robin_core_assert.svh */
// ----------------------------------------------------------------------------
// Process table assertion macros
// Concurrent property checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PROCESS_TABLE_ROUND_ROBIN_CORE_ASSERT_SVH
`define PROCESS_TABLE_ROUND_ROBIN_CORE_ASSERT_SVH
`ifndef SYNTH
`define PTRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("process table check failed");
`define PTRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("process table check failed");
`else
`define PTRR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PTRR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/ptrr_pkg.sv */
// ----------------------------------------------------------------------------
// Process table package
// Operation and status codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package ptrr_pkg;

    localparam logic [2:0] FN_TICK   = 3'd0;
    localparam logic [2:0] FN_CREATE = 3'd1;
    localparam logic [2:0] FN_FORK   = 3'd2;
    localparam logic [2:0] FN_EXIT   = 3'd3;
    localparam logic [2:0] FN_WAIT   = 3'd4;
    localparam logic [2:0] FN_LOOKUP = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SLOT  = 3'd1;
    localparam logic [2:0] ST_NO_PID   = 3'd2;
    localparam logic [2:0] ST_NOT_FND  = 3'd3;
    localparam logic [2:0] ST_RUNNING  = 3'd4;

    typedef enum logic [2:0] {
        SCAN_READY,
        SCAN_FREE,
        SCAN_ALLOC,
        SCAN_LOOKUP,
        SCAN_CHILD
    } scan_mode_t;

    typedef enum logic [2:0] {
        RES_STATUS,
        RES_TICK,
        RES_NEW,
        RES_EXIT,
        RES_REAP,
        RES_LOOK
    } res_kind_t;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DECODE = 11'b00000000010,
        S_RD1    = 11'b00000000100,
        S_RD2    = 11'b00000001000,
        S_READY  = 11'b00000010000,
        S_FREE   = 11'b00000100000,
        S_TRY    = 11'b00001000000,
        S_ALLOC  = 11'b00010000000,
        S_CHILD  = 11'b00100000000,
        S_LOOK   = 11'b01000000000,
        S_RESULT = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic       latch_in;
        logic       rd_cur;
        logic       rd_sel;
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       ctx_save;
        logic       exit_write;
        logic       me_load;
        logic       parent_one;
        logic       try_load;
        logic       pid_next;
        logic       free_load;
        logic       new_write;
        logic       reap;
        logic       load_out;
        res_kind_t  kind;
        logic [2:0] status;
    } ptrr_cmd_t;

    typedef struct packed {
        logic       scan_hit;
        logic       scan_miss;
        logic       cur_used;
        logic       tries_zero;
        logic       any_child;
        logic       out_free;
        logic [2:0] func;
    } ptrr_sts_t;

endpackage
`default_nettype wire

/* src/ptrr_ctrl.sv */
// ----------------------------------------------------------------------------
// Process table controller
// Sequences table scans, reads and writes for each operation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "process_table_round_robin_core_assert.svh"
module ptrr_ctrl
    import ptrr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire ptrr_sts_t sts,
    output ptrr_cmd_t      cmd
);

    state_t     state_reg, state_next;
    res_kind_t  kind_reg, kind_next;
    logic [2:0] status_reg, status_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kind_reg   <= RES_STATUS;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.kind    = kind_reg;
        cmd.status  = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                kind_next   = RES_STATUS;
                status_next = ST_NOT_FND;
                state_next  = S_RESULT;
                unique case (sts.func)
                    FN_TICK:
                    begin
                        cmd.ctx_save   = 1'b1;
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_READY;
                        state_next     = S_READY;
                    end
                    FN_CREATE:
                    begin
                        cmd.parent_one = 1'b1;
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_FREE;
                        state_next     = S_FREE;
                    end
                    FN_FORK, FN_WAIT:
                    begin
                        if (sts.cur_used)
                        begin
                            cmd.rd_cur = 1'b1;
                            state_next = S_RD1;
                        end
                    end
                    FN_EXIT:
                    begin
                        if (sts.cur_used)
                        begin
                            cmd.exit_write = 1'b1;
                            cmd.rd_cur     = 1'b1;
                            state_next     = S_RD1;
                        end
                    end
                    FN_LOOKUP:
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_LOOKUP;
                        state_next     = S_LOOK;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_RD1:
            begin
                state_next = S_RD2;
            end
            S_RD2:
            begin
                status_next = ST_OK;
                state_next  = S_RESULT;
                unique case (sts.func)
                    FN_TICK:
                    begin
                        kind_next = RES_TICK;
                    end
                    FN_EXIT:
                    begin
                        kind_next = RES_EXIT;
                    end
                    FN_FORK:
                    begin
                        cmd.me_load    = 1'b1;
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_FREE;
                        state_next     = S_FREE;
                    end
                    FN_WAIT:
                    begin
                        cmd.me_load    = 1'b1;
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_CHILD;
                        state_next     = S_CHILD;
                    end
                    default:
                    begin
                        kind_next   = RES_STATUS;
                        status_next = ST_NOT_FND;
                    end
                endcase
            end
            S_READY:
            begin
                if (sts.scan_hit || sts.scan_miss)
                begin
                    cmd.rd_sel = 1'b1;
                    state_next = S_RD1;
                end
            end
            S_FREE:
            begin
                if (sts.scan_hit)
                begin
                    cmd.free_load = 1'b1;
                    cmd.try_load  = 1'b1;
                    state_next    = S_TRY;
                end
                else if (sts.scan_miss)
                begin
                    kind_next   = RES_STATUS;
                    status_next = ST_NO_SLOT;
                    state_next  = S_RESULT;
                end
            end
            S_TRY:
            begin
                if (sts.tries_zero)
                begin
                    kind_next   = RES_STATUS;
                    status_next = ST_NO_PID;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.pid_next   = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_ALLOC;
                    state_next     = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                if (sts.scan_hit)
                begin
                    state_next = S_TRY;
                end
                else if (sts.scan_miss)
                begin
                    cmd.new_write = 1'b1;
                    kind_next     = RES_NEW;
                    status_next   = ST_OK;
                    state_next    = S_RESULT;
                end
            end
            S_CHILD:
            begin
                if (sts.scan_hit)
                begin
                    cmd.reap    = 1'b1;
                    kind_next   = RES_REAP;
                    status_next = ST_OK;
                    state_next  = S_RESULT;
                end
                else if (sts.scan_miss)
                begin
                    kind_next   = RES_STATUS;
                    status_next = sts.any_child ? ST_RUNNING : ST_NOT_FND;
                    state_next  = S_RESULT;
                end
            end
            S_LOOK:
            begin
                if (sts.scan_hit)
                begin
                    kind_next   = RES_LOOK;
                    status_next = ST_OK;
                    state_next  = S_RESULT;
                end
                else if (sts.scan_miss)
                begin
                    kind_next   = RES_STATUS;
                    status_next = ST_NOT_FND;
                    state_next  = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `PTRR_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.load_out, sts.out_free)
    `PTRR_ASSERT_IMP(a_hit_miss_excl, clk, rst_n, sts.scan_hit, !sts.scan_miss)
    `PTRR_ASSERT_NEXT(a_accept_decode, clk, rst_n, accept, state_reg == S_DECODE)

endmodule
`default_nettype wire

/* src/ptrr_dp.sv */
// ----------------------------------------------------------------------------
// Process table datapath
// Slot memories, used and zombie flags, scan engine, PID counter, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "process_table_round_robin_core_assert.svh"
module ptrr_dp
    import ptrr_pkg::*;
#(
    parameter int SLOTS    = 64,
    parameter int PID_BITS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ptrr_cmd_t    cmd,
    output ptrr_sts_t         sts,
    input  wire logic [2:0]   in_func,
    input  wire logic [63:0]  in_context,
    input  wire logic [63:0]  in_space,
    input  wire logic [63:0]  in_stack,
    input  wire logic [31:0]  in_exit,
    input  wire logic [15:0]  in_query,
    input  wire logic         out_ready,
    output logic              out_valid,
    output logic [2:0]        out_status,
    output logic [15:0]       out_pid,
    output logic [31:0]       out_exit,
    output logic [5:0]        out_slot,
    output logic [63:0]       out_context,
    output logic [63:0]       out_space,
    output logic [63:0]       out_stack,
    output logic              out_switched
);

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PMAX  = (1 << PID_BITS) - 1;
    localparam int TRIES = (SLOTS < PMAX) ? SLOTS : PMAX;
    localparam int TW    = $clog2(TRIES + 1);

    logic [PID_BITS-1:0] pid_mem    [SLOTS];
    logic [PID_BITS-1:0] parent_mem [SLOTS];
    logic [31:0]         exit_mem   [SLOTS];
    logic [63:0]         ctx_mem    [SLOTS];
    logic [63:0]         space_mem  [SLOTS];
    logic [63:0]         stack_mem  [SLOTS];

    logic [SLOTS-1:0]    used_reg;
    logic [SLOTS-1:0]    zombie_reg;

    logic [2:0]          func_reg;
    logic [63:0]         ctx_in_reg, space_in_reg, stack_in_reg;
    logic [31:0]         exit_in_reg;
    logic [15:0]         query_reg;

    logic [IW-1:0]       cur_reg;
    logic [PID_BITS-1:0] cnt_reg, cnt_next;
    logic [PID_BITS-1:0] cand_reg;
    logic [PID_BITS-1:0] me_reg;
    logic [TW-1:0]       tries_reg;
    logic [IW-1:0]       free_idx_reg;
    logic                switched_reg;

    logic                active_reg, rvalid_reg, any_child_reg;
    scan_mode_t          mode_reg;
    logic [IW-1:0]       raddr_reg, ridx_reg, ecnt_reg;
    logic [IW-1:0]       hit_idx_reg;
    logic [PID_BITS-1:0] hit_pid_reg;
    logic [31:0]         hit_exit_reg;

    logic [PID_BITS-1:0] rd_pid_reg, rd_parent_reg;
    logic [31:0]         rd_exit_reg;
    logic [63:0]         rd_ctx_reg, rd_space_reg, rd_stack_reg;

    logic                out_valid_reg;

    logic                u_bit, z_bit, cond, child_cond, hit, miss, cur_used;
    logic [31:0]         rd_pid_x, query_x;
    logic [IW-1:0]       sel_idx;
    logic                sel_switch;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
        return (i == IW'(SLOTS - 1)) ? '0 : i + 1'b1;
    endfunction

    assign u_bit      = used_reg[ridx_reg];
    assign z_bit      = zombie_reg[ridx_reg];
    assign cur_used   = used_reg[cur_reg];
    assign rd_pid_x   = 32'(rd_pid_reg);
    assign query_x    = 32'(query_reg);
    assign child_cond = u_bit && (rd_parent_reg == me_reg);

    always_comb
    begin
        unique case (mode_reg)
            SCAN_READY:  cond = u_bit && !z_bit;
            SCAN_FREE:   cond = !u_bit;
            SCAN_ALLOC:  cond = u_bit && (rd_pid_reg == cand_reg);
            SCAN_LOOKUP: cond = u_bit && (rd_pid_x == query_x);
            SCAN_CHILD:  cond = child_cond && z_bit;
            default:     cond = 1'b0;
        endcase
    end

    assign hit  = active_reg && rvalid_reg && cond;
    assign miss = active_reg && rvalid_reg && !cond && (ecnt_reg == IW'(SLOTS - 1));

    assign sel_switch = hit && (ridx_reg != cur_reg);
    assign sel_idx    = sel_switch ? ridx_reg : cur_reg;

    assign cnt_next = (cnt_reg == PID_BITS'(PMAX)) ? PID_BITS'(1) : cnt_reg + 1'b1;

    assign sts.scan_hit   = hit;
    assign sts.scan_miss  = miss;
    assign sts.cur_used   = cur_used;
    assign sts.tries_zero = (tries_reg == '0);
    assign sts.any_child  = any_child_reg || (rvalid_reg && child_cond);
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.func       = func_reg;

    // input and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            func_reg     <= in_func;
            ctx_in_reg   <= in_context;
            space_in_reg <= in_space;
            stack_in_reg <= in_stack;
            exit_in_reg  <= in_exit;
            query_reg    <= in_query;
        end
        if (cmd.parent_one)
            me_reg <= PID_BITS'(1);
        else if (cmd.me_load)
            me_reg <= rd_pid_reg;
        if (cmd.free_load)
            free_idx_reg <= ridx_reg;
        if (cmd.pid_next)
            cand_reg <= cnt_reg;
        if (cmd.rd_sel)
            switched_reg <= sel_switch;
        if (hit)
        begin
            hit_idx_reg  <= ridx_reg;
            hit_pid_reg  <= rd_pid_reg;
            hit_exit_reg <= rd_exit_reg;
        end
        if (cmd.try_load)
            tries_reg <= TW'(TRIES);
        else if (cmd.pid_next)
            tries_reg <= tries_reg - 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            cur_reg       <= '0;
            cnt_reg       <= PID_BITS'(1);
            active_reg    <= 1'b0;
            rvalid_reg    <= 1'b0;
            any_child_reg <= 1'b0;
            mode_reg      <= SCAN_READY;
            raddr_reg     <= '0;
            ridx_reg      <= '0;
            ecnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.new_write)
                used_reg[free_idx_reg] <= 1'b1;
            if (cmd.reap)
                used_reg[ridx_reg] <= 1'b0;
            if (cmd.rd_sel)
                cur_reg <= sel_idx;
            if (cmd.pid_next)
                cnt_reg <= cnt_next;

            if (cmd.scan_start)
            begin
                active_reg    <= 1'b1;
                rvalid_reg    <= 1'b0;
                any_child_reg <= 1'b0;
                ecnt_reg      <= '0;
                mode_reg      <= cmd.scan_mode;
                raddr_reg     <= (cmd.scan_mode == SCAN_READY) ? idx_inc(cur_reg) : '0;
            end
            else if (active_reg)
            begin
                if (hit || miss)
                begin
                    active_reg <= 1'b0;
                    rvalid_reg <= 1'b0;
                    if (cmd.rd_sel)
                        raddr_reg <= sel_idx;
                end
                else
                begin
                    raddr_reg  <= idx_inc(raddr_reg);
                    ridx_reg   <= raddr_reg;
                    rvalid_reg <= 1'b1;
                    if (rvalid_reg)
                    begin
                        ecnt_reg <= ecnt_reg + 1'b1;
                        if (child_cond)
                            any_child_reg <= 1'b1;
                    end
                end
            end
            else if (cmd.rd_cur)
                raddr_reg <= cur_reg;

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // slot memories
    always_ff @(posedge clk)
    begin
        if (cmd.exit_write)
            zombie_reg[cur_reg] <= 1'b1;
        else if (cmd.new_write)
            zombie_reg[free_idx_reg] <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.new_write)
        begin
            pid_mem[free_idx_reg]    <= cand_reg;
            parent_mem[free_idx_reg] <= me_reg;
            space_mem[free_idx_reg]  <= space_in_reg;
            stack_mem[free_idx_reg]  <= stack_in_reg;
        end
        rd_pid_reg    <= pid_mem[raddr_reg];
        rd_parent_reg <= parent_mem[raddr_reg];
        rd_space_reg  <= space_mem[raddr_reg];
        rd_stack_reg  <= stack_mem[raddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exit_write)
            exit_mem[cur_reg] <= exit_in_reg;
        else if (cmd.new_write)
            exit_mem[free_idx_reg] <= '0;
        rd_exit_reg <= exit_mem[raddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ctx_save && cur_used)
            ctx_mem[cur_reg] <= ctx_in_reg;
        else if (cmd.new_write)
            ctx_mem[free_idx_reg] <= ctx_in_reg;
        rd_ctx_reg <= ctx_mem[raddr_reg];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status   <= cmd.status;
            out_pid      <= '0;
            out_exit     <= '0;
            out_slot     <= '0;
            out_context  <= '0;
            out_space    <= '0;
            out_stack    <= '0;
            out_switched <= 1'b0;
            unique case (cmd.kind)
                RES_TICK:
                begin
                    out_slot     <= 6'(32'(cur_reg));
                    out_switched <= switched_reg;
                    out_context  <= switched_reg ? rd_ctx_reg : ctx_in_reg;
                    out_space    <= cur_used ? rd_space_reg : '0;
                    out_stack    <= cur_used ? rd_stack_reg : '0;
                end
                RES_NEW:
                begin
                    out_pid  <= 16'(32'(cand_reg));
                    out_slot <= 6'(32'(free_idx_reg));
                end
                RES_EXIT:
                begin
                    out_pid <= rd_pid_x[15:0];
                end
                RES_REAP:
                begin
                    out_pid  <= 16'(32'(hit_pid_reg));
                    out_exit <= hit_exit_reg;
                    out_slot <= 6'(32'(hit_idx_reg));
                end
                RES_LOOK:
                begin
                    out_pid  <= 16'(32'(hit_pid_reg));
                    out_slot <= 6'(32'(hit_idx_reg));
                end
                default:
                begin
                    out_switched <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

    `PTRR_ASSERT_IMP(a_cnt_nonzero, clk, rst_n, 1'b1, cnt_reg != '0)
    `PTRR_ASSERT_NEXT(a_new_used, clk, rst_n, cmd.new_write, used_reg[$past(free_idx_reg)])
    `PTRR_ASSERT_NEXT(a_reap_free, clk, rst_n, cmd.reap, !used_reg[hit_idx_reg])

endmodule
`default_nettype wire

/* src/process_table_round_robin_core.sv */
// ----------------------------------------------------------------------------
// Process table round-robin core
// Process table with round-robin tick scheduling and process lifecycle ops.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. Every table search walks the slot
// memories one slot per clock through a single read port. Create and fork take
// one free-slot walk and then one walk per PID candidate, up to
// min(SLOTS, 2^PID_BITS - 1) candidates. A finished result waits in the output
// register while the next operation is taken in. No clearing pass after reset.
`default_nettype none
module process_table_round_robin_core
    import ptrr_pkg::*;
#(
    parameter int SLOTS    = 64,
    parameter int PID_BITS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // context_handle[63:0], space_handle[127:64], stack_handle[191:128],
    // exit_value[223:192], pid_query[239:224]
    input  wire logic [239:0] s_axis_tdata,
    // func[2:0]
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[2:0], pid_out[18:3], exit_code_out[50:19], slot_out[56:51],
    // context_out[120:57], space_out[184:121], stack_out[248:185],
    // switched[249], zero[255:250]
    output logic [255:0]      m_axis_tdata
);

    ptrr_cmd_t    cmd;
    ptrr_sts_t    sts;
    logic [2:0]   status;
    logic [15:0]  pid_out;
    logic [31:0]  exit_code_out;
    logic [5:0]   slot_out;
    logic [63:0]  context_out, space_out, stack_out;
    logic         switched;

    ptrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptrr_dp #(
        .SLOTS    (SLOTS),
        .PID_BITS (PID_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_func      (s_axis_tuser),
        .in_context   (s_axis_tdata[63:0]),
        .in_space     (s_axis_tdata[127:64]),
        .in_stack     (s_axis_tdata[191:128]),
        .in_exit      (s_axis_tdata[223:192]),
        .in_query     (s_axis_tdata[239:224]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_status   (status),
        .out_pid      (pid_out),
        .out_exit     (exit_code_out),
        .out_slot     (slot_out),
        .out_context  (context_out),
        .out_space    (space_out),
        .out_stack    (stack_out),
        .out_switched (switched)
    );

    assign m_axis_tdata = {6'd0, switched, stack_out, space_out, context_out,
                           slot_out, exit_code_out, pid_out, status};

endmodule
`default_nettype wire

/* test/process_table_round_robin_core_tb.sv */
// ----------------------------------------------------------------------------
// Process table round-robin core testbench
// A directed table, then random lifecycle traffic (create, fork, tick, exit,
// wait, lookup). Every result transfer is checked field by field against the
// typed row's values or else a cycle-free table model, in three idle settings.
// ----------------------------------------------------------------------------
`default_nettype none
module process_table_round_robin_core_tb
    import ptrr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 64;
    localparam logic [2:0] FN_BAD6 = 3'd6;
    localparam logic [2:0] FN_BAD7 = 3'd7;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [239:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [255:0] m_axis_tdata;

    process_table_round_robin_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // table model
    bit          tbl_used   [NSLOT];
    bit [15:0]   tbl_pid    [NSLOT];
    bit          tbl_zombie [NSLOT];
    bit [15:0]   tbl_parent [NSLOT];
    bit [31:0]   tbl_code   [NSLOT];
    bit [63:0]   tbl_ctx    [NSLOT];
    bit [63:0]   tbl_space  [NSLOT];
    bit [63:0]   tbl_stack  [NSLOT];
    bit [5:0]    run_slot;
    bit [15:0]   pid_cursor;

    logic [255:0] pending_results[$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;

    typedef struct {
        logic [2:0]  func;
        logic [63:0] ctx;
        logic [63:0] space;
        logic [63:0] stack;
        logic [31:0] code;
        logic [15:0] pidq;
        bit          typed;
        logic [2:0]  st;
        logic [15:0] pid;
        logic [5:0]  slot;
    } row_t;

    function automatic logic [255:0] pack_result(logic [2:0] st, logic [15:0] pid,
        logic [31:0] code, logic [5:0] slot, logic [63:0] ctx, logic [63:0] space,
        logic [63:0] stack, logic sw);
        return {6'd0, sw, stack, space, ctx, slot, code, pid, st};
    endfunction

    function automatic int find_pid(logic [15:0] pid);
        for (int i = 0; i < NSLOT; i++)
            if (tbl_used[i] && tbl_pid[i] == pid)
                return i;
        return -1;
    endfunction

    function automatic logic [255:0] spawn(logic [15:0] parent, logic [63:0] ctx,
        logic [63:0] space, logic [63:0] stack);
        int idx;
        logic [15:0] pid;
        logic [15:0] cand;
        idx = -1;
        pid = '0;
        for (int i = NSLOT - 1; i >= 0; i--)
            if (!tbl_used[i])
                idx = i;
        if (idx < 0)
            return pack_result(ST_NO_SLOT, 0, 0, 0, 0, 0, 0, 0);
        for (int t = 0; t < NSLOT && pid == 0; t++)
        begin
            cand = pid_cursor;
            pid_cursor = pid_cursor + 16'd1;
            if (pid_cursor == 0)
                pid_cursor = 16'd1;
            if (find_pid(cand) < 0)
                pid = cand;
        end
        if (pid == 0)
            return pack_result(ST_NO_PID, 0, 0, 0, 0, 0, 0, 0);
        tbl_used[idx] = 1; tbl_pid[idx] = pid; tbl_zombie[idx] = 0;
        tbl_parent[idx] = parent; tbl_code[idx] = 0;
        tbl_ctx[idx] = ctx; tbl_space[idx] = space; tbl_stack[idx] = stack;
        return pack_result(ST_OK, pid, 0, 6'(idx), 0, 0, 0, 0);
    endfunction

    function automatic logic [255:0] schedule_op(logic [2:0] func, logic [63:0] ctx,
        logic [63:0] space, logic [63:0] stack, logic [31:0] code, logic [15:0] pidq);
        int found;
        int s;
        bit child;
        logic [5:0] cur;
        cur = run_slot;
        case (func)
            FN_TICK:
            begin
                found = -1;
                if (tbl_used[cur])
                    tbl_ctx[cur] = ctx;
                for (int k = 1; k <= NSLOT && found < 0; k++)
                begin
                    s = (int'(cur) + k) % NSLOT;
                    if (tbl_used[s] && !tbl_zombie[s])
                        found = s;
                end
                if (found >= 0 && found != cur)
                begin
                    run_slot = 6'(found);
                    return pack_result(ST_OK, 0, 0, 6'(found), tbl_ctx[found],
                        tbl_space[found], tbl_stack[found], 1);
                end
                if (tbl_used[cur])
                    return pack_result(ST_OK, 0, 0, cur, ctx, tbl_space[cur],
                        tbl_stack[cur], 0);
                return pack_result(ST_OK, 0, 0, cur, ctx, 0, 0, 0);
            end
            FN_CREATE: return spawn(16'd1, ctx, space, stack);
            FN_FORK:
            begin
                if (!tbl_used[cur])
                    return pack_result(ST_NOT_FND, 0, 0, 0, 0, 0, 0, 0);
                return spawn(tbl_pid[cur], ctx, space, stack);
            end
            FN_EXIT:
            begin
                if (!tbl_used[cur])
                    return pack_result(ST_NOT_FND, 0, 0, 0, 0, 0, 0, 0);
                tbl_code[cur] = code;
                tbl_zombie[cur] = 1;
                return pack_result(ST_OK, tbl_pid[cur], 0, 0, 0, 0, 0, 0);
            end
            FN_WAIT:
            begin
                child = 0;
                if (!tbl_used[cur])
                    return pack_result(ST_NOT_FND, 0, 0, 0, 0, 0, 0, 0);
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_used[i] && tbl_zombie[i] && tbl_parent[i] == tbl_pid[cur])
                    begin
                        tbl_used[i] = 0;
                        return pack_result(ST_OK, tbl_pid[i], tbl_code[i], 6'(i),
                            0, 0, 0, 0);
                    end
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_used[i] && tbl_parent[i] == tbl_pid[cur])
                        child = 1;
                return pack_result(child ? ST_RUNNING : ST_NOT_FND, 0, 0, 0, 0, 0, 0, 0);
            end
            FN_LOOKUP:
            begin
                found = find_pid(pidq);
                if (found < 0)
                    return pack_result(ST_NOT_FND, 0, 0, 0, 0, 0, 0, 0);
                return pack_result(ST_OK, pidq, 0, 6'(found), 0, 0, 0, 0);
            end
            default: return pack_result(ST_NOT_FND, 0, 0, 0, 0, 0, 0, 0);
        endcase
    endfunction

    task automatic send(row_t r);
        logic [255:0] res;
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = r.func;
        s_axis_tdata = {r.pidq, r.code, r.stack, r.space, r.ctx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = schedule_op(r.func, r.ctx, r.space, r.stack, r.code, r.pidq);
        if (r.typed)
            res = pack_result(r.st, r.pid, 0, r.slot,
                r.func == FN_TICK ? r.ctx : 64'd0, 0, 0, 0);
        pending_results.push_back(res);
        @(negedge clk);
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    localparam int FLO[8] = '{0, 3, 19, 51, 57, 121, 185, 249};
    localparam int FW[8]  = '{3, 16, 32, 6, 64, 64, 64, 1};

    always @(posedge clk)
    begin
        logic [255:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transfer %h", $time, m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                for (int f = 0; f < 8; f++)
                    if (((want ^ m_axis_tdata) >> FLO[f]) & ((256'd1 << FW[f]) - 1))
                    begin
                        errors++;
                        $display("%0t: field %0d expected %h actual %h", $time, f,
                            (want >> FLO[f]) & ((256'd1 << FW[f]) - 1),
                            (m_axis_tdata >> FLO[f]) & ((256'd1 << FW[f]) - 1));
                    end
                if (m_axis_tdata[255:250] != 0)
                begin
                    errors++;
                    $display("%0t: pad expected 0 actual %h", $time, m_axis_tdata[255:250]);
                end
            end
        end
    end

    function automatic row_t mk(logic [2:0] func, logic [63:0] ctx, logic [63:0] space,
        logic [63:0] stack, logic [31:0] code, logic [15:0] pidq);
        row_t r;
        r = '{func, ctx, space, stack, code, pidq, 0, 0, 0, 0};
        return r;
    endfunction

    function automatic row_t mkt(logic [2:0] func, logic [63:0] ctx, logic [15:0] pidq,
        logic [2:0] st, logic [15:0] pid, logic [5:0] slot);
        row_t r;
        r = '{func, ctx, 0, 0, 0, pidq, 1, st, pid, slot};
        return r;
    endfunction

    function automatic logic [63:0] r64();
        return {$urandom, $urandom};
    endfunction

    function automatic row_t rand_row(int mode);
        row_t r;
        int pick;
        int n;
        logic [15:0] q;
        pick = $urandom_range(99);
        r = mk(FN_TICK, r64(), r64(), r64(), $urandom, 16'($urandom));
        if (pick < 2)
            r.func = $urandom_range(1) ? FN_BAD6 : FN_BAD7;
        else if (mode == 1)
            r.func = pick < 45 ? FN_CREATE : pick < 75 ? FN_FORK : pick < 90 ? FN_TICK
                : FN_LOOKUP;
        else if (mode == 2)
            r.func = pick < 35 ? FN_TICK : pick < 55 ? FN_EXIT : pick < 85 ? FN_WAIT
                : pick < 90 ? FN_FORK : FN_LOOKUP;
        else
            r.func = pick < 30 ? FN_TICK : pick < 42 ? FN_CREATE : pick < 57 ? FN_FORK
                : pick < 67 ? FN_EXIT : pick < 82 ? FN_WAIT : FN_LOOKUP;
        if (r.func == FN_LOOKUP && $urandom_range(3) != 0)
        begin
            n = 0;
            q = pid_cursor - 16'd1;
            for (int i = 0; i < NSLOT; i++)
                if (tbl_used[i] && $urandom_range(n) == 0)
                begin
                    q = tbl_pid[i];
                    n++;
                end
            r.pidq = q;
        end
        return r;
    endfunction

    row_t plan[$];
    logic [63:0] ones;

    initial
    begin
        ones = '1;
        plan = '{
            mkt(FN_TICK, ones, 0, ST_OK, 0, 0),
            mkt(FN_FORK, 0, 0, ST_NOT_FND, 0, 0),
            mkt(FN_EXIT, 0, 0, ST_NOT_FND, 0, 0),
            mkt(FN_WAIT, 0, 0, ST_NOT_FND, 0, 0),
            mkt(FN_LOOKUP, 0, 16'hFFFF, ST_NOT_FND, 0, 0),
            mkt(FN_BAD6, 0, 0, ST_NOT_FND, 0, 0),
            mkt(FN_BAD7, 0, 0, ST_NOT_FND, 0, 0),
            mk(FN_CREATE, ones, ones, ones, 0, 0),
            mk(FN_CREATE, 0, 0, 0, 0, 0),
            mkt(FN_LOOKUP, 0, 16'd1, ST_OK, 16'd1, 0),
            mkt(FN_LOOKUP, 0, 16'd0, ST_NOT_FND, 0, 0),
            mk(FN_TICK, 64'h0123456789ABCDEF, 0, 0, 0, 0),
            mk(FN_TICK, 64'hFEDCBA9876543210, 0, 0, 0, 0),
            mk(FN_FORK, 64'h5555, ones, 0, 0, 0),
            mk(FN_WAIT, 0, 0, 0, 0, 0),
            mk(FN_TICK, 0, 0, 0, 0, 0),
            mk(FN_TICK, 0, 0, 0, 0, 0),
            mk(FN_EXIT, 0, 0, 0, 32'h80000000, 0),
            mk(FN_TICK, ones, 0, 0, 0, 0),
            mk(FN_WAIT, 0, 0, 0, 0, 0),
            mk(FN_WAIT, 0, 0, 0, 0, 0),
            mk(FN_EXIT, 0, 0, 0, 32'h7FFFFFFF, 0),
            mk(FN_TICK, 0, 0, 0, 0, 0),
            mk(FN_TICK, 0, 0, 0, 0, 0),
            mk(FN_LOOKUP, 0, 0, 0, 0, 16'd3)
        };
        for (int i = 0; i < NSLOT; i++)
            tbl_used[i] = 0;
        run_slot = 0;
        pid_cursor = 16'd1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int p = 0; p < 3; p++)
        begin
            send_idle = p == 0 ? 25 : p == 1 ? 58 : 0;
            recv_idle = p == 0 ? 58 : p == 1 ? 25 : 0;
            if (p == 0)
                foreach (plan[i])
                    send(plan[i]);
            for (int i = 0; i < 367; i++)
                send(rand_row(((p * 367 + i) / 60) % 3));
        end
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #300ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+src
src/ptrr_pkg.sv
src/ptrr_ctrl.sv
src/ptrr_dp.sv
src/process_table_round_robin_core.sv
test/process_table_round_robin_core_tb.sv
